[rtl/spq_pkg.sv]
// spq_pkg: shared types, codes and the priority relation for the sorted
// priority queue. No dependencies.
package spq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 3;

  typedef enum logic [1:0] {
    ActPush = 2'd0,
    ActPop  = 2'd1,
    ActPeek = 2'd2,
    ActNop  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ModeLe = 2'd0,
    ModeLt = 2'd1,
    ModeGe = 2'd2,
    ModeGt = 2'd3
  } order_mode_e;

  localparam logic [AddrW-1:0] AddrOrderMode = AddrW'(0);

  typedef enum logic [1:0] {
    OpHold = 2'd0,
    OpPush = 2'd1,
    OpPop  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic signed [DataW-1:0] element;
    logic signed [DataW-1:0] priority_v;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e    op;
    order_mode_e mode;
    entry_t      new_entry;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [DataW-1:0] element_out;
    logic signed [DataW-1:0] priority_out;
    status_e                 status;
    logic                    is_empty;
  } result_t;

  // true when entry e stays ahead of a new entry with priority n
  function automatic logic relation_holds(input order_mode_e mode,
                                          input logic signed [DataW-1:0] e,
                                          input logic signed [DataW-1:0] n);
    logic r;
    unique case (mode)
      ModeLe:  r = (e <= n);
      ModeLt:  r = (e < n);
      ModeGe:  r = (e >= n);
      default: r = (e > n);
    endcase
    return r;
  endfunction

endpackage

[rtl/spq_cell.sv]
// spq_cell: one slot of the sorted chain. Holds one entry and an occupied
// flag; shifts right on an insert ahead of it, left on pop. Uses spq_pkg.
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     left_entry_i,
  input  logic                left_occ_i,
  input  logic                left_rel_i,
  input  spq_pkg::entry_t     right_entry_i,
  input  logic                right_occ_i,
  output spq_pkg::entry_t     entry_o,
  output logic                occ_o,
  output logic                rel_o
);

  spq_pkg::entry_t entry_q, entry_d;
  logic            occ_q, occ_d;
  logic            rel;

  // occupied, ahead of the new entry and every slot before it stays too:
  // stays put on push. The AND with the left neighbor keeps the stay run a
  // prefix even when the contents were sorted under another mode.
  assign rel = left_rel_i & occ_q &
               spq_pkg::relation_holds(ctrl_i.mode, entry_q.priority_v,
                                       ctrl_i.new_entry.priority_v);

  always_comb begin
    entry_d = entry_q;
    occ_d   = occ_q;
    case (ctrl_i.op)
      spq_pkg::OpPush: begin
        occ_d = occ_q | left_occ_i;
        if (!rel) begin
          entry_d = left_rel_i ? ctrl_i.new_entry : left_entry_i;
        end
      end
      spq_pkg::OpPop: begin
        occ_d   = right_occ_i;
        entry_d = right_entry_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign occ_o   = occ_q;
  assign rel_o   = rel;

endmodule

[rtl/spq_out_buf.sv]
// spq_out_buf: two-deep output register with skid slot, so a new request
// can be taken while a result waits. Uses spq_pkg.
module spq_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  spq_pkg::result_t res_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output spq_pkg::result_t res_o
);

  spq_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic             drain;

  assign drain = out_valid_q & ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (wr_i) begin
      // skid is empty whenever wr_i is allowed
      if (!out_valid_q || drain) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (drain) begin
      out_d        = skid_q;
      out_valid_d  = skid_valid_q;
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

[rtl/sorted_priority_queue.sv]
// sorted_priority_queue: top level. Chain of spq_cell slots kept in priority
// order, APB register for the order mode, spq_out_buf on the result side.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   in      | sink      | in_valid_i/in_ready_o  | action_i, element_i, priority_req_i
//   out     | source    | out_valid_o/out_ready_i| element_out_o, priority_out_o,
//           |           |                        | status_o, is_empty_o
//   cfg     | APB slave | psel/penable/pready    | paddr, pwdata, prdata
//
// Cycles: one request per cycle while in_ready_o is high. Every cell compares
// its priority with the incoming one in parallel, so a push, pop or peek
// finishes in the accept cycle; its result goes to the output register or skid.
// Reset: all slots become unoccupied and order_mode returns to 0; no
// clearing pass is needed since stale slot payload is never exposed.
// Stalls: the output side holds two results (register plus skid slot);
// in_ready_o drops only when both are full.
module sorted_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      action_i,
  input  logic signed [spq_pkg::DataW-1:0] element_i,
  input  logic signed [spq_pkg::DataW-1:0] priority_req_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [spq_pkg::DataW-1:0] element_out_o,
  output logic signed [spq_pkg::DataW-1:0] priority_out_o,
  output logic [1:0]                      status_o,
  output logic                            is_empty_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [spq_pkg::AddrW-1:0]       paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned Depth = spq_pkg::QueueDepth;

  // ---------------- configuration register ----------------
  spq_pkg::order_mode_e mode_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= spq_pkg::ModeLe;
    end else if (psel && penable && pwrite && (paddr == spq_pkg::AddrOrderMode)) begin
      mode_q <= spq_pkg::order_mode_e'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == spq_pkg::AddrOrderMode) begin
      prdata = {30'd0, mode_q};
    end
  end

  // ---------------- cell chain ----------------
  spq_pkg::entry_t entry [Depth];
  logic            occ   [Depth];
  logic            rel   [Depth];
  spq_pkg::cell_ctrl_t ctrl;

  logic    accept;
  logic    full, empty;
  spq_pkg::action_e act;

  assign act    = spq_pkg::action_e'(action_i);
  assign accept = in_valid_i & in_ready_o;
  assign empty  = ~occ[0];
  assign full   = occ[Depth-1];

  always_comb begin
    ctrl.mode                 = mode_q;
    ctrl.new_entry.element    = element_i;
    ctrl.new_entry.priority_v = priority_req_i;
    ctrl.op                   = spq_pkg::OpHold;
    if (accept) begin
      case (act)
        spq_pkg::ActPush: if (!full)  ctrl.op = spq_pkg::OpPush;
        spq_pkg::ActPop:  if (!empty) ctrl.op = spq_pkg::OpPop;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::entry_t left_entry, right_entry;
    logic            left_occ, left_rel, right_occ;

    if (i == 0) begin : g_head
      // head takes the new entry unless it stays ahead of it
      assign left_entry = '0;
      assign left_occ   = 1'b1;
      assign left_rel   = 1'b1;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign left_occ   = occ[i-1];
      assign left_rel   = rel[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_entry = '0;
      assign right_occ   = 1'b0;
    end else begin : g_mid
      assign right_entry = entry[i+1];
      assign right_occ   = occ[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_entry_i  (left_entry),
      .left_occ_i    (left_occ),
      .left_rel_i    (left_rel),
      .right_entry_i (right_entry),
      .right_occ_i   (right_occ),
      .entry_o       (entry[i]),
      .occ_o         (occ[i]),
      .rel_o         (rel[i])
    );
  end

  // ---------------- result ----------------
  spq_pkg::result_t res, res_out;

  always_comb begin
    res.element_out  = '0;
    res.priority_out = '0;
    res.status       = spq_pkg::StatOk;
    res.is_empty     = empty;
    case (act)
      spq_pkg::ActPush: begin
        res.is_empty = 1'b0;
        if (full) res.status = spq_pkg::StatFull;
      end
      spq_pkg::ActPop, spq_pkg::ActPeek: begin
        if (empty) begin
          res.status = spq_pkg::StatEmpty;
        end else begin
          res.element_out  = entry[0].element;
          res.priority_out = entry[0].priority_v;
          // after a pop the second slot becomes the head
          if (act == spq_pkg::ActPop) res.is_empty = ~occ[1];
        end
      end
      default: ;
    endcase
  end

  spq_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .res_i   (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign element_out_o  = res_out.element_out;
  assign priority_out_o = res_out.priority_out;
  assign status_o       = res_out.status;
  assign is_empty_o     = res_out.is_empty;

endmodule
